FILE: rtl/ils_pkg.sv
package ils_pkg;

  // Store geometry.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int ST_W     = 2;

  // Requested operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ADD_HEAD = 3'd0,
    OP_ADD_TAIL = 3'd1,
    OP_INSERT   = 3'd2,
    OP_READ     = 3'd3,
    OP_DELETE   = 3'd4,
    OP_DUMP     = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Command broadcast along the row of cells.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W-1:0]  rot_last;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

  // One result as it waits in the output queue.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    status_t           status;
    logic [LEN_W-1:0]  length;
    logic              last;
  } result_t;

  // Sequencer states.
  typedef enum logic {
    S_IDLE,
    S_ROTATE
  } seq_state_t;

endpackage

FILE: rtl/ils_if.sv
// Request channel: one operation per transfer.
interface ils_in_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, output op, output position, output item_value, input ready);
  modport sink   (input valid, input op, input position, input item_value, output ready);
endinterface

// Result channel: one result per transfer.
interface ils_out_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [ST_W-1:0]          status;
  logic [LEN_W-1:0]         list_length;
  logic                     last;

  modport source (output valid, output read_value, output status, output list_length,
                  output last, input ready);
  modport sink   (input valid, input read_value, input status, input list_length,
                  input last, output ready);
endinterface

FILE: rtl/ils_cell.sv
module ils_cell (
  input  logic                      clk,
  input  ils_pkg::cell_cmd_t        cmd,
  input  logic [ils_pkg::IDX_W-1:0] idx,
  input  logic [ils_pkg::DATA_W-1:0] left,
  input  logic [ils_pkg::DATA_W-1:0] right,
  input  logic [ils_pkg::DATA_W-1:0] head,
  output logic [ils_pkg::DATA_W-1:0] entry
);
  import ils_pkg::*;

  logic [DATA_W-1:0] entry_next;

  // Each cell decides from its own index whether to hold, take a neighbour or take new data.
  always_comb begin
    entry_next = entry;
    case (cmd.op)
      CELL_INSERT: begin
        if (idx > cmd.pos) begin
          entry_next = left;
        end else if (idx == cmd.pos) begin
          entry_next = cmd.value;
        end
      end
      CELL_DELETE: begin
        if (idx >= cmd.pos) begin
          entry_next = right;
        end
      end
      CELL_ROTATE: begin
        // The last occupied cell takes the head so the sequence wraps round.
        entry_next = (idx == cmd.rot_last) ? head : right;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

FILE: rtl/ils_out_queue.sv
module ils_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ils_pkg::result_t   push_data,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output ils_pkg::result_t   out_data
);
  import ils_pkg::*;

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign can_push  = (count != 2'd2) || pop;
  assign out_data  = slots[rd_ptr];

  // Pointers and fill count of the two-entry result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/ils_seq.sv
module ils_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [ils_pkg::OP_W-1:0]   in_op,
  input  logic [ils_pkg::POS_W-1:0]  in_position,
  input  logic [ils_pkg::DATA_W-1:0] in_value,
  output logic                       in_ready,
  input  logic [ils_pkg::DATA_W-1:0] head,
  input  logic                       can_push,
  output ils_pkg::cell_cmd_t         cmd,
  output logic                       push,
  output ils_pkg::result_t           res
);
  import ils_pkg::*;

  localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

  seq_state_t       state, state_next;
  logic [LEN_W-1:0] length, length_next;
  logic [IDX_W-1:0] step, step_next;
  logic [IDX_W-1:0] target, target_next;
  logic             dump_mode, dump_mode_next;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] ins_pos;
  logic [IDX_W-1:0] rot_last;
  logic             full;

  assign pos_ext  = CMP_W'(in_position);
  assign len_ext  = CMP_W'(length);
  assign rot_last = IDX_W'(length - 1'b1);
  assign full     = (length == LEN_W'(CAPACITY));

  // Position at which an insert lands, by operation.
  always_comb begin
    case (op_t'(in_op))
      OP_ADD_HEAD: ins_pos = '0;
      OP_ADD_TAIL: ins_pos = len_ext;
      default:     ins_pos = pos_ext;
    endcase
  end

  // Next state, cell command and result.
  always_comb begin
    state_next     = state;
    length_next    = length;
    step_next      = step;
    target_next    = target;
    dump_mode_next = dump_mode;
    in_ready       = 1'b0;
    cmd.op         = CELL_HOLD;
    cmd.pos        = IDX_W'(ins_pos);
    cmd.rot_last   = rot_last;
    cmd.value      = in_value;
    push           = 1'b0;
    res.value      = '0;
    res.status     = ST_OK;
    res.length     = length;
    res.last       = 1'b1;

    case (state)
      S_IDLE: begin
        in_ready = can_push;
        if (in_valid && can_push) begin
          case (op_t'(in_op))
            OP_ADD_HEAD, OP_ADD_TAIL, OP_INSERT: begin
              push = 1'b1;
              if (ins_pos > len_ext) begin
                res.status = ST_RANGE;
              end else if (full) begin
                res.status = ST_FULL;
              end else begin
                cmd.op      = CELL_INSERT;
                length_next = length + 1'b1;
                res.length  = length + 1'b1;
              end
            end
            OP_READ: begin
              if (pos_ext < len_ext) begin
                state_next     = S_ROTATE;
                step_next      = '0;
                target_next    = IDX_W'(in_position);
                dump_mode_next = 1'b0;
              end else begin
                push       = 1'b1;
                res.status = ST_RANGE;
              end
            end
            OP_DELETE: begin
              push = 1'b1;
              if (pos_ext < len_ext) begin
                cmd.op      = CELL_DELETE;
                cmd.pos     = IDX_W'(in_position);
                length_next = length - 1'b1;
                res.length  = length - 1'b1;
              end else begin
                res.status = ST_RANGE;
              end
            end
            OP_DUMP: begin
              if (length == '0) begin
                push       = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                state_next     = S_ROTATE;
                step_next      = '0;
                dump_mode_next = 1'b1;
              end
            end
            default: begin
              push       = 1'b1;
              res.status = ST_RANGE;
            end
          endcase
        end
      end
      S_ROTATE: begin
        // Head shows entry step; the row turns by one each cycle that can_push is set.
        if (can_push) begin
          cmd.op    = CELL_ROTATE;
          step_next = step + 1'b1;
          res.value = head;
          if (dump_mode) begin
            push     = 1'b1;
            res.last = (step == rot_last);
          end else if (step == target) begin
            push = 1'b1;
          end
          if (step == rot_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      length <= '0;
    end else begin
      state  <= state_next;
      length <= length_next;
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    step      <= step_next;
    target    <= target_next;
    dump_mode <= dump_mode_next;
  end

endmodule

FILE: rtl/indexed_list_store_top.sv
// Insert, delete, out-of-range and empty-dump requests complete in their accepting
// cycle; the result is queued at the accepting edge and offered from the next cycle,
// and a new request may follow in the next cycle. A read or a non-empty dump turns
// the row of cells once round after its accepting cycle, one result per cycle for a
// dump while the result queue has room; the next request is taken after the last
// turn. A cycle in which the two-entry result queue is full and not read holds the
// row. Reset clears the length, sequencer and result queue; stored values are not reset.
module indexed_list_store_top (
  input logic       clk,
  input logic       rst,
  ils_in_if.sink    in_ch,
  ils_out_if.source out_ch
);
  import ils_pkg::*;

  cell_cmd_t         cmd;
  result_t           res;
  result_t           out_data;
  logic              push;
  logic              can_push;
  logic [DATA_W-1:0] entries [CAPACITY];

  // Operation sequencer and length register.
  ils_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_op       (in_ch.op),
    .in_position (in_ch.position),
    .in_value    (in_ch.item_value),
    .in_ready    (in_ch.ready),
    .head        (entries[0]),
    .can_push    (can_push),
    .cmd         (cmd),
    .push        (push),
    .res         (res)
  );

  // Row of storage cells linked to their neighbours; the end cells have one neighbour.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = cmd.value;
    end else begin : g_inner_left
      assign left = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_final
      assign right = entries[i];
    end else begin : g_inner_right
      assign right = entries[i+1];
    end

    ils_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .idx   (IDX_W'(i)),
      .left  (left),
      .right (right),
      .head  (entries[0]),
      .entry (entries[i])
    );
  end

  // Result queue in front of the output channel.
  ils_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.read_value  = out_data.value;
  assign out_ch.status      = out_data.status;
  assign out_ch.list_length = out_data.length;
  assign out_ch.last        = out_data.last;

endmodule
